// ===== hdl/mtip_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the MAC-to-IPv4 mapping table.
// No dependencies; imported by mac_to_ip_mapping_table.
package mtip_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 5;
    localparam int MAC_W    = 48;
    localparam int IP_W     = 32;
    localparam int OP_W     = 2;
    localparam int ST_W     = 2;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_HOLD
    } state_t;

endpackage

// ===== hdl/mac_to_ip_mapping_table.sv =====
`timescale 1ns / 1ps
// MAC-to-IPv4 mapping table: packed key and value memories with a scan sequencer.
// Depends on mtip_pkg.
//
// Usage: one input channel (in_valid/in_ready) carries a word of op, mac_addr
// and ip_addr; one output channel (out_valid/out_ready) returns exactly one
// word of status, found_ip and used_count for each input word, in order.
// Lookup (op 0) returns the stored IPv4 address, set (op 1) updates a match or
// appends a pair, remove (op 2) moves the last entry into the freed slot.
// Every operation scans the used slots from slot 0 upward through a single
// synchronous read port, one slot per cycle. A scan stops at the first hit or
// after the last used slot misses. A remove of a slot other than the last then
// reads the last entry (S_MOVE_RD) and writes it into the freed slot
// (S_MOVE_WR). The result waits in S_HOLD until the output register is free.
// The next word is accepted only after the result has entered the output
// register, so one word is handled at a time. A result waiting for out_ready
// does not block the next item from starting; if the output register is
// still occupied when a result is ready, the block holds it and waits.
// Reset empties the table at once (count to zero, no clearing pass) and drops
// any pending result.
module mac_to_ip_mapping_table
    import mtip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   op,
    input  logic [MAC_W-1:0]  mac_addr,
    input  logic [IP_W-1:0]   ip_addr,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ST_W-1:0]   status,
    output logic [IP_W-1:0]   found_ip,
    output logic [CNT_W-1:0]  used_count
);

    logic [MAC_W-1:0] key_mem [CAPACITY];
    logic [IP_W-1:0]  val_mem [CAPACITY];

    logic [MAC_W-1:0] key_rdata;
    logic [IP_W-1:0]  val_rdata;
    logic [IDX_W-1:0] rd_addr;
    logic             key_we;
    logic             val_we;
    logic [IDX_W-1:0] wr_addr;
    logic [MAC_W-1:0] wr_key;
    logic [IP_W-1:0]  wr_val;

    state_t           state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [MAC_W-1:0] mac_reg, mac_next;
    logic [IP_W-1:0]  ip_reg, ip_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [ST_W-1:0]  res_status_reg, res_status_next;
    logic [IP_W-1:0]  res_ip_reg, res_ip_next;
    logic             out_valid_reg, out_valid_next;
    logic [ST_W-1:0]  status_reg, status_next;
    logic [IP_W-1:0]  found_ip_reg, found_ip_next;
    logic [CNT_W-1:0] used_count_reg, used_count_next;

    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] last_idx;
    logic [CNT_W-1:0] cmp_idx_ext;
    logic             hit;
    logic             scan_end;

    assign cnt_m1      = count_reg - 1'b1;
    assign last_idx    = cnt_m1[IDX_W-1:0];
    assign cmp_idx_ext = CNT_W'(cmp_idx_reg);
    assign hit         = rd_valid_reg && (key_rdata == mac_reg);
    // The scan is over when the table is empty or the last used slot missed.
    assign scan_end    = (count_reg == '0) || (rd_valid_reg && !hit && (cmp_idx_ext == cnt_m1));

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (val_we)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        key_rdata <= key_mem[rd_addr];
        val_rdata <= val_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        mac_reg        <= mac_next;
        ip_reg         <= ip_next;
        issue_reg      <= issue_next;
        cmp_idx_reg    <= cmp_idx_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_ip_reg     <= res_ip_next;
        status_reg     <= status_next;
        found_ip_reg   <= found_ip_next;
        used_count_reg <= used_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        mac_next        = mac_reg;
        ip_next         = ip_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        cmp_idx_next    = cmp_idx_reg;
        rd_valid_next   = 1'b0;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_ip_next     = res_ip_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        found_ip_next   = found_ip_reg;
        used_count_next = used_count_reg;
        in_ready        = 1'b0;
        rd_addr         = issue_reg[IDX_W-1:0];
        key_we          = 1'b0;
        val_we          = 1'b0;
        wr_addr         = cmp_idx_reg;
        wr_key          = mac_reg;
        wr_val          = ip_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = op;
                    mac_next    = mac_addr;
                    ip_next     = ip_addr;
                    issue_next  = '0;
                    res_ip_next = '0;
                    if (op == OP_LOOKUP || op == OP_SET || op == OP_REMOVE)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        res_status_next = ST_MISS;
                        state_next      = S_HOLD;
                    end
                end
            end

            S_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    rd_valid_next = 1'b1;
                    cmp_idx_next  = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                end
                if (hit)
                begin
                    rd_valid_next   = 1'b0;
                    res_status_next = ST_OK;
                    state_next      = S_HOLD;
                    case (op_reg)
                        OP_LOOKUP:
                        begin
                            res_ip_next = val_rdata;
                        end
                        OP_SET:
                        begin
                            val_we  = 1'b1;
                            wr_addr = cmp_idx_reg;
                        end
                        default:
                        begin
                            slot_next = cmp_idx_reg;
                            if (cmp_idx_reg == last_idx)
                            begin
                                count_next = cnt_m1;
                            end
                            else
                            begin
                                state_next = S_MOVE_RD;
                            end
                        end
                    endcase
                end
                else if (scan_end)
                begin
                    rd_valid_next = 1'b0;
                    state_next    = S_HOLD;
                    if (op_reg == OP_SET)
                    begin
                        if (count_reg >= CAP_COUNT)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            key_we          = 1'b1;
                            val_we          = 1'b1;
                            wr_addr         = count_reg[IDX_W-1:0];
                            count_next      = count_reg + 1'b1;
                            res_status_next = ST_OK;
                        end
                    end
                    else
                    begin
                        res_status_next = ST_MISS;
                    end
                end
            end

            S_MOVE_RD:
            begin
                rd_addr    = last_idx;
                state_next = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                key_we     = 1'b1;
                val_we     = 1'b1;
                wr_addr    = slot_reg;
                wr_key     = key_rdata;
                wr_val     = val_rdata;
                count_next = cnt_m1;
                state_next = S_HOLD;
            end

            S_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    found_ip_next   = res_ip_reg;
                    used_count_next = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign found_ip   = found_ip_reg;
    assign used_count = used_count_reg;

endmodule

// ===== test/mac_to_ip_mapping_table_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mac_to_ip_mapping_table: directed and random lookup, set and
// remove words checked against a behavioral copy of the table. Depends on mtip_pkg and the RTL.
module mac_to_ip_mapping_table_tb
    import mtip_pkg::*;
();

    // The fourth selector value has no operation behind it.
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam int POOL_SIZE      = 24;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IP_W-1:0]  found_ip;
        logic [CNT_W-1:0] used_count;
    } table_reply_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [OP_W-1:0]  op = '0;
    logic [MAC_W-1:0] mac_addr = '0;
    logic [IP_W-1:0]  ip_addr = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [ST_W-1:0]  status;
    logic [IP_W-1:0]  found_ip;
    logic [CNT_W-1:0] used_count;

    // Expected contents of the table, kept in step with every accepted word.
    logic [MAC_W-1:0] tbl_mac [CAPACITY];
    logic [IP_W-1:0]  tbl_ip [CAPACITY];
    int               tbl_count = 0;

    logic [MAC_W-1:0] mac_pool [POOL_SIZE];
    table_reply_t     pending_replies [$];
    int               mismatch_count = 0;
    int               reply_index = 0;
    int               quiet_cycles = 0;

    bit               send_idle_on = 1'b1;
    bit               ready_idle_on = 1'b1;
    int               hold_requests = 0;
    int               hold_seen = 0;
    int               hold_left = 0;

    mac_to_ip_mapping_table dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .mac_addr   (mac_addr),
        .ip_addr    (ip_addr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found_ip   (found_ip),
        .used_count (used_count)
    );

    always #5 clk = ~clk;

    function automatic int find_slot(input logic [MAC_W-1:0] key);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_mac[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic table_reply_t table_apply(input logic [OP_W-1:0] w_op,
                                                 input logic [MAC_W-1:0] w_mac,
                                                 input logic [IP_W-1:0] w_ip);
        table_reply_t r;
        int           slot;
        r.status   = ST_MISS;
        r.found_ip = '0;
        slot = find_slot(w_mac);
        case (w_op)
            OP_LOOKUP:
            begin
                if (slot >= 0)
                begin
                    r.status   = ST_OK;
                    r.found_ip = tbl_ip[slot];
                end
            end
            OP_SET:
            begin
                if (slot >= 0)
                begin
                    tbl_ip[slot] = w_ip;
                    r.status = ST_OK;
                end
                else if (tbl_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    tbl_mac[tbl_count] = w_mac;
                    tbl_ip[tbl_count]  = w_ip;
                    tbl_count++;
                    r.status = ST_OK;
                end
            end
            OP_REMOVE:
            begin
                // The last entry fills the hole so the table stays packed.
                if (slot >= 0)
                begin
                    tbl_mac[slot] = tbl_mac[tbl_count-1];
                    tbl_ip[slot]  = tbl_ip[tbl_count-1];
                    tbl_count--;
                    r.status = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
        r.used_count = CNT_W'(tbl_count);
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[MAC_W-1:0];
    endfunction

    function automatic logic [IP_W-1:0] random_ip();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return '1;
        return $urandom();
    endfunction

    // Mostly keys from a small pool so that hits, updates and a full table are common.
    function automatic logic [MAC_W-1:0] pick_mac();
        logic [MAC_W-1:0] k;
        int               r;
        int               b;
        r = $urandom_range(0, 99);
        if (r < 60)
            return mac_pool[$urandom_range(0, POOL_SIZE-1)];
        if (r < 75 && tbl_count > 0)
            return tbl_mac[$urandom_range(0, tbl_count-1)];
        if (r < 90)
            return random_mac();
        // A near miss: a stored-looking key with a single bit flipped.
        k = mac_pool[$urandom_range(0, POOL_SIZE-1)];
        b = $urandom_range(0, MAC_W-1);
        k[b] = ~k[b];
        return k;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic set_idling(input bit on);
        send_idle_on = on;
        ready_idle_on <= on;
    endtask

    // Offers one word, holds it until accepted, and records the reply it must produce.
    task automatic send_word(input logic [OP_W-1:0] w_op, input logic [MAC_W-1:0] w_mac,
                             input logic [IP_W-1:0] w_ip);
        if (send_idle_on)
        begin
            while ($urandom_range(0, 99) < 34)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        op       <= w_op;
        mac_addr <= w_mac;
        ip_addr  <= w_ip;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_replies.push_back(table_apply(w_op, w_mac, w_ip));
    endtask

    task automatic test_empty_table();
        send_word(OP_LOOKUP, random_mac(), random_ip());
        send_word(OP_REMOVE, random_mac(), random_ip());
        send_word(OP_NONE, '1, '1);
    endtask

    task automatic test_edge_keys();
        send_word(OP_SET, '0, '1);
        send_word(OP_SET, '1, '0);
        send_word(OP_LOOKUP, '0, '1);
        send_word(OP_LOOKUP, '1, '1);
        send_word(OP_SET, '0, 32'h0A00_0001);
        send_word(OP_LOOKUP, 48'h0000_0000_0001, '0);
        send_word(OP_LOOKUP, 48'h8000_0000_0000, '0);
        send_word(OP_NONE, '0, '0);
        send_word(OP_REMOVE, '0, '0);
        send_word(OP_LOOKUP, '1, '0);
        send_word(OP_REMOVE, '1, '1);
        send_word(OP_LOOKUP, '1, '0);
    endtask

    task automatic test_random_mix(input int n_words);
        int r;
        for (int i = 0; i < n_words; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_word(OP_LOOKUP, pick_mac(), random_ip());
            else if (r < 68)
                send_word(OP_SET, pick_mac(), random_ip());
            else if (r < 94)
                send_word(OP_REMOVE, pick_mac(), random_ip());
            else
                send_word(OP_NONE, random_mac(), random_ip());
        end
    endtask

    task automatic test_fill_and_drain();
        logic [MAC_W-1:0] key;
        key = random_mac();
        set_idling(1'b0);
        // Enough fresh keys to fill the table from any level and then bounce off it.
        repeat (CAPACITY + 3)
            send_word(OP_SET, random_mac(), random_ip());
        send_word(OP_SET, tbl_mac[$urandom_range(0, CAPACITY-1)], random_ip());
        send_word(OP_LOOKUP, tbl_mac[CAPACITY-1], '0);
        set_idling(1'b1);
        while (tbl_count > 0)
        begin
            key = tbl_mac[$urandom_range(0, tbl_count-1)];
            send_word(OP_REMOVE, key, random_ip());
            if ($urandom_range(0, 2) == 0)
                send_word(OP_LOOKUP, key, '0);
        end
        send_word(OP_REMOVE, key, random_ip());
    endtask

    // Idling stays off afterwards; the next test turns it back on.
    task automatic test_output_stall();
        set_idling(1'b0);
        hold_requests <= hold_requests + 1;
        repeat (12)
        begin
            if ($urandom_range(0, 1) == 0)
                send_word(OP_LOOKUP, pick_mac(), random_ip());
            else
                send_word(OP_SET, pick_mac(), random_ip());
        end
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ready_idle_on ? ($urandom_range(0, 99) >= 34) : 1'b1;
    end

    always @(posedge clk)
    begin
        table_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
                report_mismatch($sformatf("reply %0d with no word pending: status %0d ip %h count %0d",
                                          reply_index, status, found_ip, used_count));
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                              reply_index, status, want.status));
                if (found_ip !== want.found_ip)
                    report_mismatch($sformatf("reply %0d found_ip %h, expected %h",
                                              reply_index, found_ip, want.found_ip));
                if (used_count !== want.used_count)
                    report_mismatch($sformatf("reply %0d used_count %0d, expected %0d",
                                              reply_index, used_count, want.used_count));
            end
            reply_index++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR @%0t: no word moved for %0d cycles", $realtime, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            mac_pool[i] = random_mac();

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_edge_keys();
        test_random_mix(300);
        test_fill_and_drain();
        test_output_stall();
        test_fill_and_drain();
        test_random_mix(300);

        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
